[rtl/core/pfts_pkg.sv]
// Package for the priority FIFO thread scheduler: item types, event kind codes,
// controller states and the run queue control and status structs.
// Depends on nothing.
`default_nettype none

package pfts_pkg;

    // Widths of the external item fields.
    typedef logic [2:0] kind_field_t;
    typedef logic [2:0] id_field_t;
    typedef logic [1:0] prio_field_t;

    // Widest thread id and level index that the parameter ranges allow.
    localparam int ID_MAX_W  = 6;
    localparam int LVL_MAX_W = 4;

    // Event kinds.
    localparam kind_field_t KIND_CREATE     = 3'd0;
    localparam kind_field_t KIND_WAKE       = 3'd1;
    localparam kind_field_t KIND_YIELD      = 3'd2;
    localparam kind_field_t KIND_SUSPEND    = 3'd3;
    localparam kind_field_t KIND_WAKE_SCHED = 3'd4;
    localparam kind_field_t KIND_START      = 3'd5;

    typedef struct packed {
        kind_field_t kind;
        id_field_t   thread_id;
        prio_field_t priority_req;
    } in_item_t;

    typedef struct packed {
        id_field_t running_id;
        logic      running_valid;
        id_field_t returned_id;
        logic      error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQUEUE,
        ST_WAKE,
        ST_POP,
        ST_LOAD,
        ST_FINISH
    } state_t;

    // Controller to run queue.
    typedef struct packed {
        logic                 push;
        logic [LVL_MAX_W-1:0] push_lvl;
        logic [ID_MAX_W-1:0]  push_id;
        logic                 pop;
    } runq_ctl_t;

    // Run queue to controller. pop_id is valid in the cycle after a pop.
    typedef struct packed {
        logic                 ready;
        logic [LVL_MAX_W-1:0] pop_lvl;
        logic [ID_MAX_W-1:0]  pop_id;
    } runq_stat_t;

endpackage

`default_nettype wire

[rtl/core/priority_fifo_thread_scheduler.sv]
// Top level of the priority FIFO thread scheduler: event sequencer, thread
// table, running-thread registers and result register.
// Depends on pfts_pkg and pfts_runq.
//
//   Channel   Ports                        Carries
//   input     s_valid, s_ready, s_item     one scheduler event (kind, id, level)
//   result    m_valid, m_ready, m_item     running thread, returned id, error
//
// One event at a time is worked on. Each run queue access has a state of its
// own: the requeue of the running thread, the wake or create push, and the pop
// with its registered memory read. Unknown kinds go straight to the finish
// state; the load state is skipped when nothing is popped. Pushes land in
// memory before the pop reads.
// A new event is taken while the previous result still waits in the output
// register; the sequencer stalls in its last state only if that register is
// still full. Reset is synchronous and needs no clearing pass.
`default_nettype none

module priority_fifo_thread_scheduler #(
    parameter int MAX_THREADS = 8,
    parameter int LEVELS      = 4
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  pfts_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  wire                 m_ready,
    output pfts_pkg::out_item_t m_item
);

    localparam int ID_W  = $clog2(MAX_THREADS);
    localparam int LVL_W = $clog2(LEVELS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

    pfts_pkg::state_t     state_reg, state_next;
    pfts_pkg::in_item_t   item_reg, item_next;
    pfts_pkg::out_item_t  m_item_reg, m_item_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ID_W-1:0]      cur_id_reg, cur_id_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [LVL_W-1:0]     cur_lvl_reg, cur_lvl_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [MAX_THREADS-1:0] susp_reg, susp_next;
    logic [LVL_W-1:0]     level_reg [MAX_THREADS];
    logic [LVL_W-1:0]     level_next [MAX_THREADS];
    pfts_pkg::id_field_t  ret_reg, ret_next;
    logic                 err_reg, err_next;

    pfts_pkg::runq_ctl_t  rq_ctl;
    pfts_pkg::runq_stat_t rq_stat;

    logic                 accept;
    logic                 pop_go;
    logic                 out_free;
    logic                 tid_ok;
    logic [ID_W-1:0]      tid_idx;
    logic [ID_W-1:0]      new_id;
    logic [LVL_W-1:0]     new_lvl;

    pfts_runq #(
        .MAX_THREADS(MAX_THREADS),
        .LEVELS     (LEVELS)
    ) u_runq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (rq_ctl),
        .stat   (rq_stat)
    );

    assign s_ready  = (state_reg == pfts_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // Start leaves a running thread alone; otherwise pop if anything is queued.
    assign pop_go = !((item_reg.kind == pfts_pkg::KIND_START) && cur_valid_reg)
                    && rq_stat.ready;

    assign tid_ok  = CMP_W'(item_reg.thread_id) < CMP_W'(count_reg);
    assign tid_idx = ID_W'(item_reg.thread_id);
    assign new_id  = ID_W'(count_reg);
    assign new_lvl = (32'(item_reg.priority_req) >= 32'(LEVELS)) ? LVL_W'(LEVELS - 1)
                                                                 : LVL_W'(item_reg.priority_req);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfts_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_item.kind)
                        pfts_pkg::KIND_CREATE,
                        pfts_pkg::KIND_WAKE:       state_next = pfts_pkg::ST_WAKE;
                        pfts_pkg::KIND_YIELD,
                        pfts_pkg::KIND_SUSPEND,
                        pfts_pkg::KIND_WAKE_SCHED: state_next = pfts_pkg::ST_REQUEUE;
                        pfts_pkg::KIND_START:      state_next = pfts_pkg::ST_POP;
                        default:                   state_next = pfts_pkg::ST_FINISH;
                    endcase
                end
            end
            pfts_pkg::ST_REQUEUE: begin
                if (item_reg.kind == pfts_pkg::KIND_WAKE_SCHED) begin
                    state_next = pfts_pkg::ST_WAKE;
                end else begin
                    state_next = pfts_pkg::ST_POP;
                end
            end
            pfts_pkg::ST_WAKE: begin
                if (item_reg.kind == pfts_pkg::KIND_WAKE_SCHED) begin
                    state_next = pfts_pkg::ST_POP;
                end else begin
                    state_next = pfts_pkg::ST_FINISH;
                end
            end
            pfts_pkg::ST_POP: begin
                state_next = pop_go ? pfts_pkg::ST_LOAD : pfts_pkg::ST_FINISH;
            end
            pfts_pkg::ST_LOAD: begin
                state_next = pfts_pkg::ST_FINISH;
            end
            pfts_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = pfts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        item_next      = item_reg;
        m_item_next    = m_item_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cur_id_next    = cur_id_reg;
        cur_valid_next = cur_valid_reg;
        cur_lvl_next   = cur_lvl_reg;
        count_next     = count_reg;
        susp_next      = susp_reg;
        level_next     = level_reg;
        ret_next       = ret_reg;
        err_next       = err_reg;
        rq_ctl         = '0;

        case (state_reg)
            pfts_pkg::ST_IDLE: begin
                if (accept) begin
                    item_next = s_item;
                    ret_next  = '0;
                    err_next  = 1'b0;
                end
            end
            pfts_pkg::ST_REQUEUE: begin
                // The running thread is never marked suspended while it runs,
                // so a requeue always goes to the tail of its own level.
                if (cur_valid_reg) begin
                    if (item_reg.kind == pfts_pkg::KIND_SUSPEND) begin
                        susp_next[cur_id_reg] = 1'b1;
                        ret_next              = pfts_pkg::id_field_t'(cur_id_reg);
                    end else begin
                        rq_ctl.push     = 1'b1;
                        rq_ctl.push_lvl = pfts_pkg::LVL_MAX_W'(cur_lvl_reg);
                        rq_ctl.push_id  = pfts_pkg::ID_MAX_W'(cur_id_reg);
                    end
                end
            end
            pfts_pkg::ST_WAKE: begin
                if (item_reg.kind == pfts_pkg::KIND_CREATE) begin
                    if (count_reg >= CNT_W'(MAX_THREADS)) begin
                        err_next = 1'b1;
                    end else begin
                        level_next[new_id] = new_lvl;
                        susp_next[new_id]  = 1'b0;
                        count_next         = CNT_W'(count_reg + 1'b1);
                        ret_next           = pfts_pkg::id_field_t'(count_reg);
                        rq_ctl.push        = 1'b1;
                        rq_ctl.push_lvl    = pfts_pkg::LVL_MAX_W'(new_lvl);
                        rq_ctl.push_id     = pfts_pkg::ID_MAX_W'(new_id);
                    end
                end else if (tid_ok && susp_reg[tid_idx]) begin
                    susp_next[tid_idx] = 1'b0;
                    rq_ctl.push        = 1'b1;
                    rq_ctl.push_lvl    = pfts_pkg::LVL_MAX_W'(level_reg[tid_idx]);
                    rq_ctl.push_id     = pfts_pkg::ID_MAX_W'(tid_idx);
                end
            end
            pfts_pkg::ST_POP: begin
                if (pop_go) begin
                    rq_ctl.pop   = 1'b1;
                    cur_lvl_next = LVL_W'(rq_stat.pop_lvl);
                end else if (!((item_reg.kind == pfts_pkg::KIND_START) && cur_valid_reg)) begin
                    err_next       = 1'b1;
                    cur_valid_next = 1'b0;
                    cur_id_next    = '0;
                end
            end
            pfts_pkg::ST_LOAD: begin
                cur_id_next    = ID_W'(rq_stat.pop_id);
                cur_valid_next = 1'b1;
            end
            pfts_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_item_next.running_id    = cur_valid_reg
                                                ? pfts_pkg::id_field_t'(cur_id_reg) : '0;
                    m_item_next.running_valid = cur_valid_reg;
                    m_item_next.returned_id   = ret_reg;
                    m_item_next.error         = err_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pfts_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            cur_id_reg    <= '0;
            cur_valid_reg <= 1'b0;
            cur_lvl_reg   <= LVL_W'(LEVELS - 1);
            count_reg     <= CNT_W'(1);
            susp_reg      <= {{(MAX_THREADS - 1){1'b1}}, 1'b0};
            for (int i = 0; i < MAX_THREADS; i++) begin
                level_reg[i] <= (i == 0) ? LVL_W'(LEVELS - 1) : '0;
            end
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            cur_id_reg    <= cur_id_next;
            cur_valid_reg <= cur_valid_next;
            cur_lvl_reg   <= cur_lvl_next;
            count_reg     <= count_next;
            susp_reg      <= susp_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        m_item_reg <= m_item_next;
        ret_reg    <= ret_next;
        err_reg    <= err_next;
    end

endmodule

`default_nettype wire

[rtl/core/pfts_runq.sv]
// Per-level FIFO run queues: one ring store per level in a shared memory with
// a registered read port, plus head and fill registers for each level.
// Depends on pfts_pkg.
`default_nettype none

module pfts_runq #(
    parameter int MAX_THREADS = 8,
    parameter int LEVELS      = 4
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  pfts_pkg::runq_ctl_t  ctl,
    output pfts_pkg::runq_stat_t stat
);

    localparam int ID_W   = $clog2(MAX_THREADS);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int CNT_W  = $clog2(MAX_THREADS + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DEPTH  = LEVELS * MAX_THREADS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [ID_W-1:0]   head_reg [LEVELS];
    logic [CNT_W-1:0]  fill_reg [LEVELS];
    logic [ID_W-1:0]   mem [DEPTH];
    logic [ID_W-1:0]   rd_data_reg;
    logic              seed_reg;

    logic [LVL_W-1:0]  push_lvl;
    logic [ID_W-1:0]   push_id;
    logic [SUM_W-1:0]  push_sum;
    logic [ID_W-1:0]   push_slot;
    logic [ADDR_W-1:0] push_addr;
    logic              push_ok;
    logic [LVL_W-1:0]  pop_lvl;
    logic              any_ready;
    logic [ADDR_W-1:0] pop_addr;

    assign push_lvl = LVL_W'(ctl.push_lvl);
    assign push_id  = ID_W'(ctl.push_id);
    assign push_ok  = ctl.push && (fill_reg[push_lvl] < CNT_W'(MAX_THREADS));

    // The tail slot is head plus fill, wrapped once around the ring.
    always_comb begin
        push_sum = SUM_W'(head_reg[push_lvl]) + SUM_W'(fill_reg[push_lvl]);
        if (push_sum >= SUM_W'(MAX_THREADS)) begin
            push_slot = ID_W'(push_sum - SUM_W'(MAX_THREADS));
        end else begin
            push_slot = ID_W'(push_sum);
        end
        push_addr = ADDR_W'(ADDR_W'(push_lvl) * ADDR_W'(MAX_THREADS) + ADDR_W'(push_slot));
    end

    // Highest non-empty level, level 0 being the highest.
    always_comb begin
        pop_lvl   = '0;
        any_ready = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (fill_reg[i] != '0) begin
                pop_lvl   = LVL_W'(i);
                any_ready = 1'b1;
            end
        end
        pop_addr = ADDR_W'(ADDR_W'(pop_lvl) * ADDR_W'(MAX_THREADS) + ADDR_W'(head_reg[pop_lvl]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= (i == LEVELS - 1) ? CNT_W'(1) : '0;
            end
            seed_reg <= 1'b1;
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                if (push_ok && (push_lvl == LVL_W'(i))) begin
                    fill_reg[i] <= CNT_W'(fill_reg[i] + 1'b1);
                end
                if (ctl.pop && any_ready && (pop_lvl == LVL_W'(i))) begin
                    fill_reg[i] <= CNT_W'(fill_reg[i] - 1'b1);
                    if (head_reg[i] == ID_W'(MAX_THREADS - 1)) begin
                        head_reg[i] <= '0;
                    end else begin
                        head_reg[i] <= ID_W'(head_reg[i] + 1'b1);
                    end
                end
            end
            // The idle thread sits at the head of the lowest level from reset
            // without ever having been written; its first pop clears the flag.
            if (ctl.pop && any_ready && (pop_lvl == LVL_W'(LEVELS - 1))) begin
                seed_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[push_addr] <= push_id;
        end
        if (ctl.pop) begin
            if (seed_reg && (pop_lvl == LVL_W'(LEVELS - 1))) begin
                rd_data_reg <= '0;
            end else begin
                rd_data_reg <= mem[pop_addr];
            end
        end
    end

    assign stat.ready   = any_ready;
    assign stat.pop_lvl = pfts_pkg::LVL_MAX_W'(pop_lvl);
    assign stat.pop_id  = pfts_pkg::ID_MAX_W'(rd_data_reg);

endmodule

`default_nettype wire

[verif/tb_priority_fifo_thread_scheduler.sv]
// Self-checking testbench for priority_fifo_thread_scheduler: directed and random scheduler
// events, checked against a behavioural run-queue scheduler written here.
// Depends on pfts_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_priority_fifo_thread_scheduler;

    localparam int MAX_THREADS = 8;
    localparam int LEVELS      = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;

    // Kinds that the block decodes as no operation.
    localparam pfts_pkg::kind_field_t KIND_SPARE_6 = 3'd6;
    localparam pfts_pkg::kind_field_t KIND_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        TH_SUSPENDED,
        TH_RUNNABLE,
        TH_RUNNING
    } thread_state_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pfts_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    pfts_pkg::out_item_t m_item;

    priority_fifo_thread_scheduler #(
        .MAX_THREADS(MAX_THREADS),
        .LEVELS     (LEVELS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Scheduler state as the testbench sees it.
    thread_state_t         thread_st  [MAX_THREADS];
    pfts_pkg::prio_field_t thread_lvl [MAX_THREADS];
    int                    thread_total;
    pfts_pkg::id_field_t   lvl_store  [LEVELS*MAX_THREADS];
    int                    lvl_head   [LEVELS];
    int                    lvl_fill   [LEVELS];
    pfts_pkg::id_field_t   cur_id;
    logic                  cur_valid;

    pfts_pkg::out_item_t predicted_outcomes[$];
    pfts_pkg::out_item_t oldest_outcome;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    bit        idle_en        = 1'b0;
    int        stall_left     = 0;

    function automatic void enqueue_thread(int lvl, pfts_pkg::id_field_t id);
        if (lvl >= LEVELS || lvl_fill[lvl] >= MAX_THREADS)
            return;
        lvl_store[lvl*MAX_THREADS + (lvl_head[lvl] + lvl_fill[lvl]) % MAX_THREADS] = id;
        lvl_fill[lvl]++;
    endfunction

    function automatic void wake_thread(pfts_pkg::id_field_t id);
        if (int'(id) >= thread_total || thread_st[id] != TH_SUSPENDED)
            return;
        thread_st[id] = TH_RUNNABLE;
        enqueue_thread(int'(thread_lvl[id]), id);
    endfunction

    // Pops the head of the highest non-empty level; returns 1 when nothing is runnable.
    function automatic logic dispatch_next();
        pfts_pkg::id_field_t id;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            if (lvl_fill[lvl] != 0) begin
                id = lvl_store[lvl*MAX_THREADS + lvl_head[lvl]];
                lvl_head[lvl] = (lvl_head[lvl] + 1) % MAX_THREADS;
                lvl_fill[lvl]--;
                thread_st[id] = TH_RUNNING;
                cur_id    = id;
                cur_valid = 1'b1;
                return 1'b0;
            end
        end
        cur_id    = '0;
        cur_valid = 1'b0;
        return 1'b1;
    endfunction

    // The running thread goes to the tail of its own level.
    function automatic void requeue_running();
        if (cur_valid) begin
            thread_st[cur_id] = TH_SUSPENDED;
            wake_thread(cur_id);
        end
    endfunction

    function automatic pfts_pkg::out_item_t apply_sched_event(pfts_pkg::in_item_t ev);
        pfts_pkg::out_item_t res;
        int                  new_id;
        res = '0;
        case (ev.kind)
            pfts_pkg::KIND_CREATE: begin
                if (thread_total >= MAX_THREADS) begin
                    res.error = 1'b1;
                end else begin
                    new_id = thread_total;
                    thread_total++;
                    thread_lvl[new_id] = (int'(ev.priority_req) >= LEVELS) ?
                                         pfts_pkg::prio_field_t'(LEVELS - 1) : ev.priority_req;
                    thread_st[new_id] = TH_SUSPENDED;
                    wake_thread(pfts_pkg::id_field_t'(new_id));
                    res.returned_id = pfts_pkg::id_field_t'(new_id);
                end
            end
            pfts_pkg::KIND_WAKE: wake_thread(ev.thread_id);
            pfts_pkg::KIND_YIELD: begin
                requeue_running();
                res.error = dispatch_next();
            end
            pfts_pkg::KIND_SUSPEND: begin
                if (cur_valid) begin
                    res.returned_id   = cur_id;
                    thread_st[cur_id] = TH_SUSPENDED;
                end
                res.error = dispatch_next();
            end
            pfts_pkg::KIND_WAKE_SCHED: begin
                requeue_running();
                wake_thread(ev.thread_id);
                res.error = dispatch_next();
            end
            pfts_pkg::KIND_START: begin
                if (!cur_valid)
                    res.error = dispatch_next();
            end
            default: ;
        endcase
        res.running_id    = cur_valid ? cur_id : '0;
        res.running_valid = cur_valid;
        return res;
    endfunction

    task automatic report_mismatch(string what, pfts_pkg::out_item_t want,
                                   pfts_pkg::out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected run=%0d/%0d ret=%0d err=%0d, %s",
                     $realtime, what, want.running_id, want.running_valid,
                     want.returned_id, want.error,
                     $sformatf("got run=%0d/%0d ret=%0d err=%0d", got.running_id,
                               got.running_valid, got.returned_id, got.error));
    endtask

    // Predict on every accepted event, then check any result against the oldest prediction.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready)
                predicted_outcomes.push_back(apply_sched_event(s_item));
            if (m_valid && m_ready) begin
                if (predicted_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_item);
                end else begin
                    oldest_outcome = predicted_outcomes.pop_front();
                    if (m_item.running_id    !== oldest_outcome.running_id    ||
                        m_item.running_valid !== oldest_outcome.running_valid ||
                        m_item.returned_id   !== oldest_outcome.returned_id   ||
                        m_item.error         !== oldest_outcome.error)
                        report_mismatch("result mismatch", oldest_outcome, m_item);
                end
            end
        end
    end

    // Random result side back-pressure in bursts, only while idle_en is set.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_event(pfts_pkg::kind_field_t kind, pfts_pkg::id_field_t tid,
                              pfts_pkg::prio_field_t prio);
        pfts_pkg::in_item_t ev;
        int                 gap;
        ev.kind         = kind;
        ev.thread_id    = tid;
        ev.priority_req = prio;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= ev;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (predicted_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_random_events(int count, int wake_pct, int suspend_pct);
        pfts_pkg::kind_field_t kind;
        int                    pick;
        int                    sent;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                kind = pfts_pkg::KIND_CREATE;
            else if (pick < 5 + wake_pct)
                kind = pfts_pkg::KIND_WAKE;
            else if (pick < 5 + wake_pct + suspend_pct)
                kind = pfts_pkg::KIND_SUSPEND;
            else if (pick < 95)
                case ($urandom_range(0, 2))
                    0:       kind = pfts_pkg::KIND_YIELD;
                    1:       kind = pfts_pkg::KIND_WAKE_SCHED;
                    default: kind = pfts_pkg::KIND_START;
                endcase
            else
                kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_6 : KIND_SPARE_7;
            send_event(kind, pfts_pkg::id_field_t'($urandom_range(0, 7)),
                       pfts_pkg::prio_field_t'($urandom_range(0, 3)));
            if (kind != KIND_SPARE_6 && kind != KIND_SPARE_7)
                sent++;
        end
    endtask

    task automatic test_directed_events();
        // Empty schedules first, while the idle thread is the only one.
        send_event(pfts_pkg::KIND_START,      3'd7, 2'd3);
        send_event(pfts_pkg::KIND_START,      3'd0, 2'd0);
        send_event(KIND_SPARE_6,              3'd7, 2'd3);
        send_event(KIND_SPARE_7,              3'd0, 2'd0);
        send_event(pfts_pkg::KIND_YIELD,      3'd0, 2'd0);
        send_event(pfts_pkg::KIND_SUSPEND,    3'd0, 2'd0);
        send_event(pfts_pkg::KIND_SUSPEND,    3'd0, 2'd0);
        send_event(pfts_pkg::KIND_YIELD,      3'd0, 2'd0);
        send_event(pfts_pkg::KIND_WAKE_SCHED, 3'd3, 2'd0);
        send_event(pfts_pkg::KIND_START,      3'd0, 2'd0);
        send_event(pfts_pkg::KIND_WAKE,       3'd7, 2'd0);
        send_event(pfts_pkg::KIND_WAKE,       3'd0, 2'd0);
        send_event(pfts_pkg::KIND_WAKE,       3'd0, 2'd0);
        send_event(pfts_pkg::KIND_START,      3'd0, 2'd0);
        // Fill the thread table across every level; the last create finds it full.
        send_event(pfts_pkg::KIND_CREATE, 3'd7, 2'd0);
        send_event(pfts_pkg::KIND_CREATE, 3'd0, 2'd3);
        send_event(pfts_pkg::KIND_CREATE, 3'd0, 2'd1);
        send_event(pfts_pkg::KIND_CREATE, 3'd0, 2'd2);
        send_event(pfts_pkg::KIND_CREATE, 3'd0, 2'd0);
        send_event(pfts_pkg::KIND_CREATE, 3'd0, 2'd3);
        send_event(pfts_pkg::KIND_CREATE, 3'd0, 2'd1);
        send_event(pfts_pkg::KIND_CREATE, 3'd0, 2'd2);
        send_event(pfts_pkg::KIND_SUSPEND,    3'd0, 2'd0);
        send_event(pfts_pkg::KIND_YIELD,      3'd0, 2'd0);
        send_event(pfts_pkg::KIND_WAKE_SCHED, 3'd0, 2'd0);
    endtask

    task automatic test_mixed_traffic();
        idle_en = 1'b1;
        run_random_events(700, 30, 20);
    endtask

    // Suspend-heavy traffic keeps emptying the run queues.
    task automatic test_starvation_traffic();
        idle_en = 1'b1;
        run_random_events(500, 15, 40);
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        run_random_events(330, 25, 25);
    endtask

    initial begin
        for (int i = 0; i < MAX_THREADS; i++) begin
            thread_st[i]  = TH_SUSPENDED;
            thread_lvl[i] = '0;
        end
        for (int i = 0; i < LEVELS; i++) begin
            lvl_head[i] = 0;
            lvl_fill[i] = 0;
        end
        // The idle thread starts queued at the lowest level.
        thread_st[0]  = TH_RUNNABLE;
        thread_lvl[0] = pfts_pkg::prio_field_t'(LEVELS - 1);
        thread_total  = 1;
        lvl_store[(LEVELS - 1)*MAX_THREADS] = '0;
        lvl_fill[LEVELS - 1] = 1;
        cur_id    = '0;
        cur_valid = 1'b0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_events();
        test_mixed_traffic();
        wait_for_results();
        test_starvation_traffic();
        test_back_to_back();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && predicted_outcomes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
